// ===== hw/rtl/pasr_pkg.sv =====
// Shared constants, types and helpers of the packet address swap reflector.
`default_nettype none

package pasr_pkg;

    // Delay line and parser sizing
    localparam int DELAY_DEPTH   = 32;
    localparam int MAX_VLAN_TAGS = 4;
    localparam int CNT_W         = $clog2(DELAY_DEPTH + 1);
    localparam int POS_W         = 16;
    localparam int TAG_W         = 3;
    localparam int OFF_W         = 6;

    // Ethernet constants
    localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ_A = 16'h9100;
    localparam logic [15:0] ETYPE_QINQ_B = 16'h9200;
    localparam logic [15:0] ETYPE_QINQ_C = 16'h9300;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam int          MAC_ADDR_LEN = 6;

    // L3 address layout, offsets from the start of the L3 header
    localparam int IPV4_SRC_OFF  = 12;
    localparam int IPV4_ADDR_LEN = 4;
    localparam int IPV4_LAST     = IPV4_SRC_OFF + 2 * IPV4_ADDR_LEN - 1;
    localparam int IPV6_SRC_OFF  = 8;
    localparam int IPV6_ADDR_LEN = 16;
    localparam int IPV6_LAST     = IPV6_SRC_OFF + 2 * IPV6_ADDR_LEN - 1;

    // Swap done on the current step
    localparam logic [1:0] SWAP_NONE = 2'd0;
    localparam logic [1:0] SWAP_MAC  = 2'd1;
    localparam logic [1:0] SWAP_V4   = 2'd2;
    localparam logic [1:0] SWAP_V6   = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } cell_t;

    typedef struct packed {
        logic advance;
        logic take_alt;
    } cell_ctrl_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] swap;
    } step_t;

    // Partner cell (by age, after the shift) of cell j for a given swap, or -1.
    // The two fields of each pair are adjacent and end at the newest byte.
    function automatic int swap_partner(logic [1:0] code, int j);
        int span;
        span = 0;
        case (code)
            SWAP_MAC: span = MAC_ADDR_LEN;
            SWAP_V4:  span = IPV4_ADDR_LEN;
            SWAP_V6:  span = IPV6_ADDR_LEN;
            default:  span = 0;
        endcase
        if (j < span)
            return j + span;
        else if (j < 2 * span)
            return j - span;
        else
            return -1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/packet_address_swap_reflector.sv =====
// Top level of the packet address swap reflector: cell chain, flush and output register.
`default_nettype none

// Channel  Handshake             Payload                          Item
// -------  --------------------  -------------------------------  -------------------------
// in       in_valid / in_ready   data_byte, frame_end, drop_frame  one frame byte
// out      out_valid / out_ready out_byte, out_last               one rewritten frame byte
//
// Once the chain holds DELAY_DEPTH bytes, each new byte pushes the oldest one
// into the output register. The last byte of a kept frame starts a flush, in
// which the cell chain shifts toward its old end and no input item is taken,
// until the last held byte has left. A stalled output holds the chain whenever
// a byte would have to leave it. Reset clears the cell valid bits, the parser
// state and the output valid bit.

module packet_address_swap_reflector (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_end,
    input  wire logic       drop_frame,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    localparam int DEPTH = pasr_pkg::DELAY_DEPTH;
    localparam int CW    = pasr_pkg::CNT_W;

    pasr_pkg::cell_t      cell_q    [DEPTH];
    pasr_pkg::cell_t      cell_left [DEPTH];
    pasr_pkg::cell_ctrl_t cell_ctrl [DEPTH];
    logic [7:0]           cell_alt  [DEPTH];
    pasr_pkg::step_t      step;

    logic          flushing_reg;
    logic          flushing_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic in_accept;
    logic slot_free;
    logic full;
    logic push;
    logic flush_step;
    logic out_load;

    assign slot_free  = !out_valid_reg || out_ready;
    assign full       = (count_reg == CW'(DEPTH));
    // Take a byte unless flushing, or unless it would push out a byte with nowhere to go
    assign in_ready   = !flushing_reg && (!full || slot_free);
    assign in_accept  = in_valid && in_ready;
    assign push       = in_accept && !step.drop;
    assign flush_step = flushing_reg && slot_free;

    pasr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .drop_frame (drop_frame),
        .prev_byte  (cell_q[0].data),
        .step       (step)
    );

    // Newest byte enters cell 0; each cell hands its byte to the next older one
    assign cell_left[0].valid = push;
    assign cell_left[0].data  = data_byte;

    genvar j;
    generate
        for (j = 1; j < DEPTH; j++)
        begin : g_link
            assign cell_left[j] = cell_q[j-1];
        end

        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            localparam int PM  = pasr_pkg::swap_partner(pasr_pkg::SWAP_MAC, j);
            localparam int PV4 = pasr_pkg::swap_partner(pasr_pkg::SWAP_V4, j);
            localparam int PV6 = pasr_pkg::swap_partner(pasr_pkg::SWAP_V6, j);
            localparam int IM  = (PM  < 0) ? 0 : PM;
            localparam int IV4 = (PV4 < 0) ? 0 : PV4;
            localparam int IV6 = (PV6 < 0) ? 0 : PV6;

            logic hit;

            // Swap partner takes what its own left neighbor hands in this step
            always_comb
            begin
                hit         = 1'b0;
                cell_alt[j] = cell_left[j].data;
                case (step.swap)
                    pasr_pkg::SWAP_MAC:
                    begin
                        hit         = (PM >= 0);
                        cell_alt[j] = cell_left[IM].data;
                    end
                    pasr_pkg::SWAP_V4:
                    begin
                        hit         = (PV4 >= 0);
                        cell_alt[j] = cell_left[IV4].data;
                    end
                    pasr_pkg::SWAP_V6:
                    begin
                        hit         = (PV6 >= 0);
                        cell_alt[j] = cell_left[IV6].data;
                    end
                    default:
                    begin
                        hit = 1'b0;
                    end
                endcase
            end

            assign cell_ctrl[j].advance  = push || flush_step;
            assign cell_ctrl[j].take_alt = push && hit;

            pasr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl[j]),
                .left     (cell_left[j]),
                .alt_data (cell_alt[j]),
                .q        (cell_q[j])
            );
        end
    endgenerate

    always_comb
    begin
        flushing_next  = flushing_reg;
        count_next     = count_reg;
        out_load       = 1'b0;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (push)
        begin
            // Full chain: the oldest byte leaves as the new one enters
            if (full)
            begin
                out_load      = 1'b1;
                out_byte_next = cell_q[DEPTH-1].data;
                out_last_next = 1'b0;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
            if (frame_end)
                flushing_next = 1'b1;
        end
        else if (flush_step)
        begin
            // Empty cells drain first; drop the flush with the last held byte
            if (cell_q[DEPTH-1].valid)
            begin
                out_load      = 1'b1;
                out_byte_next = cell_q[DEPTH-1].data;
                out_last_next = (count_reg == CW'(1));
                count_next    = count_reg - CW'(1);
                if (count_reg == CW'(1))
                    flushing_next = 1'b0;
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flushing_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flushing_reg  <= flushing_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> !in_ready)
        else $error("input taken during flush");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("held byte count beyond chain depth");

    a_flush_holds_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> (count_reg != '0))
        else $error("flush with no byte held");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("output register overwritten");

    a_oldest_valid_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cell_q[DEPTH-1].valid)
        else $error("full chain with empty oldest cell");

endmodule

`default_nettype wire

// ===== hw/rtl/pasr_cell.sv =====
// One byte cell of the delay line: takes its left neighbor or a swap partner.
`default_nettype none

module pasr_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pasr_pkg::cell_ctrl_t ctrl,
    input  wire pasr_pkg::cell_t     left,
    input  wire logic [7:0]          alt_data,
    output pasr_pkg::cell_t          q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.advance)
        begin
            valid_next = left.valid;
            data_next  = ctrl.take_alt ? alt_data : left.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q.valid = valid_reg;
    assign q.data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pasr_parser.sv =====
// Frame header parser: drop verdict, VLAN tag skipping and swap timing.
`default_nettype none

module pasr_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           frame_end,
    input  wire logic           drop_frame,
    input  wire logic [7:0]     prev_byte,
    output pasr_pkg::step_t     step
);

    localparam logic [1:0] KIND_PARSE = 2'd0;
    localparam logic [1:0] KIND_V4    = 2'd1;
    localparam logic [1:0] KIND_V6    = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    logic [pasr_pkg::POS_W-1:0] pos_reg;
    logic [pasr_pkg::POS_W-1:0] pos_next;
    logic [pasr_pkg::OFF_W-1:0] l3_off_reg;
    logic [pasr_pkg::OFF_W-1:0] l3_off_next;
    logic [pasr_pkg::TAG_W-1:0] tag_reg;
    logic [pasr_pkg::TAG_W-1:0] tag_next;
    logic [1:0]                 kind_reg;
    logic [1:0]                 kind_next;
    logic                       dropping_reg;
    logic                       dropping_next;

    logic                       drop_now;
    logic [1:0]                 swap;
    logic [pasr_pkg::OFF_W-1:0] tp;
    logic [15:0]                ethertype;
    logic                       is_tag;

    always_comb
    begin
        drop_now  = (pos_reg == '0) ? drop_frame : dropping_reg;
        tp        = pasr_pkg::OFF_W'(2 * pasr_pkg::MAC_ADDR_LEN) + {1'b0, tag_reg, 2'b00};
        ethertype = {prev_byte, data_byte};
        is_tag    = (ethertype == pasr_pkg::ETYPE_VLAN) || (ethertype == pasr_pkg::ETYPE_QINQ_A)
                 || (ethertype == pasr_pkg::ETYPE_QINQ_B)
                 || (ethertype == pasr_pkg::ETYPE_QINQ_C);

        swap          = pasr_pkg::SWAP_NONE;
        pos_next      = pos_reg;
        l3_off_next   = l3_off_reg;
        tag_next      = tag_reg;
        kind_next     = kind_reg;
        dropping_next = dropping_reg;

        if (!drop_now)
        begin
            if (pos_reg == pasr_pkg::POS_W'(2 * pasr_pkg::MAC_ADDR_LEN - 1))
                swap = pasr_pkg::SWAP_MAC;

            case (kind_reg)
                KIND_PARSE:
                begin
                    // Ethertype completes on its second byte
                    if (pos_reg == ({{(pasr_pkg::POS_W - pasr_pkg::OFF_W){1'b0}}, tp}
                                    + pasr_pkg::POS_W'(1)))
                    begin
                        if (is_tag)
                        begin
                            if (tag_reg < pasr_pkg::TAG_W'(pasr_pkg::MAX_VLAN_TAGS))
                                tag_next = tag_reg + pasr_pkg::TAG_W'(1);
                            else
                                kind_next = KIND_NONE;
                        end
                        else if (ethertype == pasr_pkg::ETYPE_IPV4)
                        begin
                            kind_next   = KIND_V4;
                            l3_off_next = tp + pasr_pkg::OFF_W'(2);
                        end
                        else if (ethertype == pasr_pkg::ETYPE_IPV6)
                        begin
                            kind_next   = KIND_V6;
                            l3_off_next = tp + pasr_pkg::OFF_W'(2);
                        end
                        else
                        begin
                            kind_next = KIND_NONE;
                        end
                    end
                end
                KIND_V4:
                begin
                    if (pos_reg == ({{(pasr_pkg::POS_W - pasr_pkg::OFF_W){1'b0}}, l3_off_reg}
                                    + pasr_pkg::POS_W'(pasr_pkg::IPV4_LAST)))
                        swap = pasr_pkg::SWAP_V4;
                end
                KIND_V6:
                begin
                    if (pos_reg == ({{(pasr_pkg::POS_W - pasr_pkg::OFF_W){1'b0}}, l3_off_reg}
                                    + pasr_pkg::POS_W'(pasr_pkg::IPV6_LAST)))
                        swap = pasr_pkg::SWAP_V6;
                end
                default:
                begin
                    swap = swap;
                end
            endcase
        end

        dropping_next = drop_now;
        if (frame_end)
        begin
            pos_next      = '0;
            l3_off_next   = '0;
            tag_next      = '0;
            kind_next     = KIND_PARSE;
            dropping_next = 1'b0;
        end
        else if (pos_reg != {pasr_pkg::POS_W{1'b1}})
        begin
            pos_next = pos_reg + pasr_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            l3_off_reg   <= '0;
            tag_reg      <= '0;
            kind_reg     <= KIND_PARSE;
            dropping_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            l3_off_reg   <= l3_off_next;
            tag_reg      <= tag_next;
            kind_reg     <= kind_next;
            dropping_reg <= dropping_next;
        end
    end

    assign step.drop = drop_now;
    assign step.swap = swap;

endmodule

`default_nettype wire

// ===== tb/tb_packet_address_swap_reflector.sv =====
// Self-checking testbench for the packet address swap reflector.
`timescale 1ns / 1ps

module tb_packet_address_swap_reflector;

    // Run sizing
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DEPTH        = pasr_pkg::DELAY_DEPTH;
    localparam int MAC_LEN      = pasr_pkg::MAC_ADDR_LEN;
    localparam int LIMIT_CYCLES = 100_000;
    localparam int SETTLE       = DEPTH + 16;
    localparam int HOLD_CYCLES  = 3 * DEPTH + 40;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    localparam logic [15:0] VLAN_TYPES [4] = '{pasr_pkg::ETYPE_VLAN, pasr_pkg::ETYPE_QINQ_A,
                                               pasr_pkg::ETYPE_QINQ_B, pasr_pkg::ETYPE_QINQ_C};

    // Parser progress of the current frame
    typedef enum logic [1:0] {
        L3_PENDING,
        L3_IPV4,
        L3_IPV6,
        L3_OTHER
    } hdr_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

    // DUT connections; every input starts at a known value
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte  = 8'h00;
    logic       frame_end  = 1'b0;
    logic       drop_frame = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    // Predictor state: its own copy of the delay line and the parser
    logic [7:0]  line_mem [DEPTH];
    int unsigned line_head;
    int unsigned line_fill;
    logic [15:0] frame_pos;
    int unsigned hdr_off;
    int unsigned vlan_seen;
    hdr_kind_t   hdr_kind;
    bit          discarding;

    // Bytes the block still owes us, oldest first
    out_item_t reflected_q [$];

    // Frame under construction
    logic [7:0] frame_bytes [$];

    // Traffic shaping knobs: send idle and receive stall in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ready_hold     = 0;

    // Bookkeeping
    int mismatches     = 0;
    int bytes_in       = 0;
    int bytes_out      = 0;
    int frames_sent    = 0;
    int frames_dropped = 0;
    int cycle_count    = 0;

    packet_address_swap_reflector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .drop_frame (drop_frame),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return to the start-of-frame parser state.
    function automatic void clear_frame();
        frame_pos  = '0;
        hdr_off    = 0;
        vlan_seen  = 0;
        hdr_kind   = L3_PENDING;
        discarding = 1'b0;
    endfunction

    // Find the line slot of frame byte q while byte p is the newest one.
    function automatic bit locate(input int unsigned q, input int unsigned p,
                                  output int unsigned slot);
        int unsigned age;
        slot = 0;
        if (q > p)
            return 1'b0;
        age = p - q;
        if (age >= line_fill)
            return 1'b0;
        slot = (line_head + 2 * DEPTH - 1 - age) % DEPTH;
        return 1'b1;
    endfunction

    // Swap two equal-length fields in place, skipping bytes already gone.
    function automatic void swap_span(input int unsigned a, input int unsigned b,
                                      input int unsigned len, input int unsigned p);
        int unsigned k;
        int unsigned sa;
        int unsigned sb;
        logic [7:0]  t;
        for (k = 0; k < len; k++)
        begin
            if (locate(a + k, p, sa) && locate(b + k, p, sb))
            begin
                t            = line_mem[sa];
                line_mem[sa] = line_mem[sb];
                line_mem[sb] = t;
            end
        end
    endfunction

    function automatic bit is_vlan(input logic [15:0] et);
        return et == pasr_pkg::ETYPE_VLAN || et == pasr_pkg::ETYPE_QINQ_A ||
               et == pasr_pkg::ETYPE_QINQ_B || et == pasr_pkg::ETYPE_QINQ_C;
    endfunction

    // Take one accepted byte and queue every byte it pushes out.
    function automatic void reflect_byte(input logic [7:0] b, input logic last,
                                         input logic drop);
        int unsigned p;
        int unsigned slot;
        int unsigned tp;
        logic [15:0] et;

        // Sample the verdict on the first byte only
        if (frame_pos == 0)
            discarding = drop;
        if (discarding)
        begin
            if (last)
                clear_frame();
            else if (frame_pos != POS_MAX)
                frame_pos++;
            return;
        end

        // A full line pushes its oldest byte out
        if (line_fill >= DEPTH)
        begin
            slot = (line_head + DEPTH - line_fill) % DEPTH;
            reflected_q.push_back('{data: line_mem[slot], last: 1'b0});
            line_fill = DEPTH - 1;
        end
        line_mem[line_head] = b;
        line_head = (line_head + 1) % DEPTH;
        line_fill++;

        p = frame_pos;
        if (p == 2 * MAC_LEN - 1)
            swap_span(0, MAC_LEN, MAC_LEN, p);

        case (hdr_kind)
            L3_PENDING:
            begin
                tp = 2 * MAC_LEN + 4 * vlan_seen;
                if (p == tp + 1 && locate(p - 1, p, slot))
                begin
                    et = {line_mem[slot], b};
                    if (is_vlan(et))
                    begin
                        if (vlan_seen < pasr_pkg::MAX_VLAN_TAGS)
                            vlan_seen++;
                        else
                            hdr_kind = L3_OTHER;
                    end
                    else if (et == pasr_pkg::ETYPE_IPV4)
                    begin
                        hdr_kind = L3_IPV4;
                        hdr_off  = tp + 2;
                    end
                    else if (et == pasr_pkg::ETYPE_IPV6)
                    begin
                        hdr_kind = L3_IPV6;
                        hdr_off  = tp + 2;
                    end
                    else
                        hdr_kind = L3_OTHER;
                end
            end
            L3_IPV4:
                if (p == hdr_off + pasr_pkg::IPV4_LAST)
                    swap_span(hdr_off + pasr_pkg::IPV4_SRC_OFF,
                              hdr_off + pasr_pkg::IPV4_SRC_OFF + pasr_pkg::IPV4_ADDR_LEN,
                              pasr_pkg::IPV4_ADDR_LEN, p);
            L3_IPV6:
                if (p == hdr_off + pasr_pkg::IPV6_LAST)
                    swap_span(hdr_off + pasr_pkg::IPV6_SRC_OFF,
                              hdr_off + pasr_pkg::IPV6_SRC_OFF + pasr_pkg::IPV6_ADDR_LEN,
                              pasr_pkg::IPV6_ADDR_LEN, p);
            default: ;
        endcase

        // The last byte flushes everything still held
        if (last)
        begin
            while (line_fill > 0)
            begin
                slot = (line_head + DEPTH - line_fill) % DEPTH;
                reflected_q.push_back('{data: line_mem[slot], last: line_fill == 1});
                line_fill--;
            end
            clear_frame();
        end
        else if (frame_pos != POS_MAX)
            frame_pos++;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            out_ready  <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted output byte against the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_out++;
            if (reflected_q.size() == 0)
            begin
                $display("%0t: expected no byte, actual %02h last %0b",
                         $time, out_byte, out_last);
                mismatches++;
            end
            else
            begin
                want = reflected_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, out_byte);
                    mismatches++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last, out_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d bytes still owed", $time, reflected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then predict its results.
    task automatic send_byte(input logic [7:0] value, input logic last, input logic drop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        frame_end  <= last;
        drop_frame <= drop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_in++;
        reflect_byte(value, last, drop);
    endtask

    // Send the built frame. Later bytes carry either random drop bits or the
    // opposite of the first one, so a verdict resampled mid-frame shows up.
    task automatic send_frame(input logic drop_first, input logic scramble);
        int   i;
        int   n;
        logic rest;
        n = frame_bytes.size();
        for (i = 0; i < n; i++)
        begin
            rest = scramble ? 1'($urandom) : ~drop_first;
            send_byte(frame_bytes[i], i == n - 1, (i == 0) ? drop_first : rest);
        end
        frames_sent++;
        if (drop_first)
            frames_dropped++;
    endtask

    // Drop valid and wait until every owed byte has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reflected_q.size() != 0)
            @(posedge clk);
    endtask

    // Length of the full header chain up to the end of the L3 header.
    function automatic int full_length(input logic [15:0] ethertype, input int tag_total);
        int l3;
        l3 = (ethertype == pasr_pkg::ETYPE_IPV4) ? pasr_pkg::IPV4_LAST + 1 :
             (ethertype == pasr_pkg::ETYPE_IPV6) ? pasr_pkg::IPV6_LAST + 1 : 0;
        return 2 * MAC_LEN + 4 * tag_total + 2 + l3;
    endfunction

    // Build MACs, a tag stack cycling through all tag types, the ethertype
    // and random payload, then cut or pad to the given length.
    task automatic build_frame(input logic [15:0] ethertype, input int tag_total,
                               input int length);
        int          base;
        int          t;
        logic [15:0] tag_type;
        frame_bytes = {};
        repeat (2 * MAC_LEN)
            frame_bytes.push_back(8'($urandom));
        base = $urandom_range(3);
        for (t = 0; t < tag_total; t++)
        begin
            tag_type = VLAN_TYPES[(base + t) % 4];
            frame_bytes.push_back(tag_type[15:8]);
            frame_bytes.push_back(tag_type[7:0]);
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
        end
        frame_bytes.push_back(ethertype[15:8]);
        frame_bytes.push_back(ethertype[7:0]);
        while (frame_bytes.size() < length)
            frame_bytes.push_back(8'($urandom));
        while (frame_bytes.size() > length)
            void'(frame_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No idling: single-byte frames at the byte extremes, one kept and one
    // dropped, a frame one short of the MAC swap, and one cut inside the
    // ethertype.
    task automatic test_short_frames();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frame_bytes = {};
        frame_bytes.push_back(8'hFF);
        send_frame(1'b0, 1'b0);
        frame_bytes = {};
        frame_bytes.push_back(8'h00);
        send_frame(1'b1, 1'b0);
        build_frame(pasr_pkg::ETYPE_IPV4, 0, 2 * MAC_LEN - 1);
        send_frame(1'b0, 1'b1);
        build_frame(pasr_pkg::ETYPE_IPV4, 0, 2 * MAC_LEN + 1);
        send_frame(1'b0, 1'b0);
        wait_drain();
    endtask

    // Sender idle most cycles: tagged IPv4 whose last byte completes the
    // destination address, so the swap lands on the flushing byte.
    task automatic test_ipv4();
        send_idle_pct  = 70;
        recv_stall_pct = 0;
        build_frame(pasr_pkg::ETYPE_IPV4, 1, full_length(pasr_pkg::ETYPE_IPV4, 1));
        send_frame(1'b0, 1'b1);
        wait_drain();
    endtask

    // Receiver stalling, with a long hold-off at the start so the line
    // fills and the input stalls while the sender keeps offering an IPv6
    // frame long enough for the address swap.
    task automatic test_ipv6_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        ready_hold     = HOLD_CYCLES;
        build_frame(pasr_pkg::ETYPE_IPV6, 0, full_length(pasr_pkg::ETYPE_IPV6, 0));
        send_frame(1'b0, 1'b1);
        wait_drain();
    endtask

    // Both sides idle: a dropped frame must vanish whole and leave the
    // parser clean, then a stack one tag deeper than allowed, cut right
    // after the type of the tag that is one too many.
    task automatic test_drop_and_tags();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        build_frame(pasr_pkg::ETYPE_IPV4, 0, 8);
        send_frame(1'b1, 1'b0);
        build_frame(pasr_pkg::ETYPE_IPV4, pasr_pkg::MAX_VLAN_TAGS + 1,
                    2 * MAC_LEN + 4 * pasr_pkg::MAX_VLAN_TAGS + 2);
        send_frame(1'b0, 1'b1);
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (line_mem[i])
            line_mem[i] = 8'h00;
        line_head = 0;
        line_fill = 0;
        clear_frame();

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_ipv4();
        test_ipv6_stall();
        test_drop_and_tags();

        // Let any stray output surface before judging
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drain();
        repeat (SETTLE)
            @(posedge clk);

        $display("covered %0d frames (%0d dropped), %0d bytes in, %0d bytes out",
                 frames_sent, frames_dropped, bytes_in, bytes_out);
        $display("MAC/IPv4/IPv6 swaps, deep tag stack, cut headers, drops, idle and stalls");
        if (mismatches == 0 && reflected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== packet_address_swap_reflector.f =====
hw/rtl/pasr_pkg.sv
hw/rtl/pasr_cell.sv
hw/rtl/pasr_parser.sv
hw/rtl/packet_address_swap_reflector.sv
tb/tb_packet_address_swap_reflector.sv
